### rtl/tbd_pkg.sv
// shared types, constants and helpers for the three-button debouncer
// used by tbd_lane, tbd_merge and three_button_debounce_fsm_core
`default_nettype none

package tbd_pkg;

  // button lanes: hardware slots and how many of them are populated (1 to 3)
  localparam int NUM_BTN      = 3;
  localparam int BUTTON_COUNT = 3;

  // field widths
  localparam int HIST_W   = 5;
  localparam int PERIOD_W = 10;
  localparam int TIME_W   = 16;
  localparam int MODE_W   = 2;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // stream widths, padded to whole bytes
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_FIELD_W = NUM_BTN * (MODE_W + 2 * TIME_W);
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_TICK_PERIOD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASED_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESSED_LIMIT  = 2'd2;

  // reset values of the configuration registers
  localparam logic [PERIOD_W-1:0] TICK_PERIOD_RST = 10'd10;
  localparam logic [TIME_W-1:0]   TIME_LIMIT_RST  = 16'd5000;

  // button modes as seen on the result stream
  typedef enum logic [MODE_W-1:0] {
    MODE_RELEASED     = 2'd0,
    MODE_PRE_PRESSED  = 2'd1,
    MODE_PRESSED      = 2'd2,
    MODE_PRE_RELEASED = 2'd3
  } mode_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] tick_period;
    logic [TIME_W-1:0]   released_limit;
    logic [TIME_W-1:0]   pressed_limit;
  } cfg_t;

  typedef struct packed {
    mode_t             mode;
    logic [TIME_W-1:0] held;
    logic [TIME_W-1:0] idle;
  } lane_res_t;

  // add one tick period unless the limit is reached, saturating at the top
  function automatic logic [TIME_W-1:0] grow_time(input logic [TIME_W-1:0]   t,
                                                  input logic [TIME_W-1:0]   limit,
                                                  input logic [PERIOD_W-1:0] period);
    logic [TIME_W:0] sum;
    sum = {1'b0, t} + {{(TIME_W + 1 - PERIOD_W){1'b0}}, period};
    if (t >= limit) begin
      grow_time = t;
    end else if (sum[TIME_W]) begin
      grow_time = TIME_MAX;
    end else begin
      grow_time = sum[TIME_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

### rtl/three_button_debounce_fsm_core.sv
// Three-button debouncer with per-button four-state machines.
// Input stream: one beat per sampling tick, in_tdata bits [2:0] carry the raw
// active-low levels of select, plus and minus (0 pressed, 1 released).
// Output stream: one beat per input beat with each button's mode (released,
// pre-pressed, pressed, pre-released) and its pressed and released times in ms.
// Config port: cfg_index 0 tick period, 1 released limit, 2 pressed limit;
// writes to index 3 are dropped. cfg_ready is always high; write only when idle.
// A beat's result is registered and on out_tdata in the cycle after acceptance.
// Throughput: one beat per cycle unless stalled; one lane per button, all three
// lanes update in the accepting cycle and the merge stage registers the packed
// beat. While the receiver stalls, the held beat stays put and in_tready drops
// until it is taken; in_tready is high again in the cycle it leaves.
// Reset (rst_n low, synchronous): histories go to all released, modes to
// released, times to zero, registers to 10 ms / 5000 / 5000, output empty.
// depends on tbd_pkg, tbd_lane, tbd_merge
`default_nettype none

module three_button_debounce_fsm_core (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // in_tdata: [0] select_level, [1] plus_level, [2] minus_level, [7:3] zero
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [tbd_pkg::IN_TDATA_W-1:0]     in_tdata,
  // out_tdata: [1:0] select_mode, [3:2] plus_mode, [5:4] minus_mode,
  // [21:6] select_held_ms, [37:22] plus_held_ms, [53:38] minus_held_ms,
  // [69:54] select_idle_ms, [85:70] plus_idle_ms, [101:86] minus_idle_ms,
  // [103:102] zero
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [tbd_pkg::OUT_TDATA_W-1:0]         out_tdata,
  // configuration write channel
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [tbd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [tbd_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import tbd_pkg::*;

  localparam int HELD0_LO = NUM_BTN * MODE_W;
  localparam int IDLE0_LO = NUM_BTN * (MODE_W + TIME_W);

  cfg_t                      cfg_r;
  logic                      accept;
  logic                      merge_ready;
  lane_res_t [NUM_BTN-1:0]   lane_res;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tick_period    <= TICK_PERIOD_RST;
      cfg_r.released_limit <= TIME_LIMIT_RST;
      cfg_r.pressed_limit  <= TIME_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TICK_PERIOD:    cfg_r.tick_period    <= cfg_data[PERIOD_W-1:0];
        CFG_RELEASED_LIMIT: cfg_r.released_limit <= cfg_data[TIME_W-1:0];
        CFG_PRESSED_LIMIT:  cfg_r.pressed_limit  <= cfg_data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // input handshake
  assign in_tready = merge_ready;
  assign accept    = in_tvalid && in_tready;

  // one lane per populated button, unpopulated slots read zero
  for (genvar b = 0; b < NUM_BTN; b++) begin : g_lane
    if (b < BUTTON_COUNT) begin : g_used
      tbd_lane u_lane (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .level  (in_tdata[b]),
        .cfg    (cfg_r),
        .res    (lane_res[b])
      );
    end else begin : g_unused
      assign lane_res[b] = '0;
    end
  end

  // merge stage and output register
  tbd_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .lane_res   (lane_res),
    .in_ready   (merge_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // checks

  // a stalled result blocks new input
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input accepted while output stalled");

  // every accepted beat produces a result next cycle
  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted beat produced no result");

  // pressed time is zero while select is released or about to press
  a_held_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[MODE_W-1:0] == MODE_RELEASED ||
                   out_tdata[MODE_W-1:0] == MODE_PRE_PRESSED)
    |-> out_tdata[HELD0_LO +: TIME_W] == '0)
    else $error("select held time nonzero while released");

  // released time is zero while select is pressed or about to release
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[MODE_W-1:0] == MODE_PRESSED ||
                   out_tdata[MODE_W-1:0] == MODE_PRE_RELEASED)
    |-> out_tdata[IDLE0_LO +: TIME_W] == '0)
    else $error("select idle time nonzero while pressed");

endmodule

`default_nettype wire

### rtl/tbd_lane.sv
// one button lane: sample history, four-state debounce machine, time counters
// depends on tbd_pkg
`default_nettype none

module tbd_lane (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               accept,
  input  wire logic               level,
  input  wire tbd_pkg::cfg_t      cfg,
  output tbd_pkg::lane_res_t      res
);
  import tbd_pkg::*;

  logic [HIST_W-1:0] history_r;
  logic [HIST_W-1:0] history_nxt;
  mode_t             mode_r;
  mode_t             mode_nxt;
  logic [TIME_W-1:0] held_r;
  logic [TIME_W-1:0] held_nxt;
  logic [TIME_W-1:0] idle_r;
  logic [TIME_W-1:0] idle_nxt;
  logic [1:0]        new2;
  logic [2:0]        new3;
  logic [1:0]        old2;

  // newest sample enters at the top
  assign history_nxt = {level, history_r[HIST_W-1:1]};
  assign new2 = history_nxt[HIST_W-1:HIST_W-2];
  assign new3 = history_nxt[HIST_W-1:HIST_W-3];
  assign old2 = history_nxt[1:0];

  // debounce machine and counter update for this beat
  always_comb begin
    mode_nxt = mode_r;
    held_nxt = held_r;
    idle_nxt = idle_r;
    case (mode_r)
      MODE_RELEASED: begin
        if (new2 == 2'b00 && old2 == 2'b11) begin
          mode_nxt = MODE_PRE_PRESSED;
          idle_nxt = '0;
        end else begin
          idle_nxt = grow_time(idle_r, cfg.released_limit, cfg.tick_period);
        end
      end
      MODE_PRE_PRESSED: begin
        if (new3 == 3'b000) mode_nxt = MODE_PRESSED;
      end
      MODE_PRESSED: begin
        if (new2 == 2'b11 && old2 == 2'b00) begin
          mode_nxt = MODE_PRE_RELEASED;
          held_nxt = '0;
        end else begin
          held_nxt = grow_time(held_r, cfg.pressed_limit, cfg.tick_period);
        end
      end
      MODE_PRE_RELEASED: begin
        if (new3 == 3'b111) mode_nxt = MODE_RELEASED;
      end
      default: mode_nxt = MODE_RELEASED;
    endcase
  end

  // lane state, advanced once per accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      history_r <= '1;
      mode_r    <= MODE_RELEASED;
      held_r    <= '0;
      idle_r    <= '0;
    end else if (accept) begin
      history_r <= history_nxt;
      mode_r    <= mode_nxt;
      held_r    <= held_nxt;
      idle_r    <= idle_nxt;
    end
  end

  // results carry the values after this beat's update
  assign res.mode = mode_nxt;
  assign res.held = held_nxt;
  assign res.idle = idle_nxt;

endmodule

`default_nettype wire

### rtl/tbd_merge.sv
// merge stage: packs the lane results into one output beat and holds it
// depends on tbd_pkg
`default_nettype none

module tbd_merge (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire logic                                     accept,
  input  wire tbd_pkg::lane_res_t [tbd_pkg::NUM_BTN-1:0] lane_res,
  output logic                                          in_ready,
  output logic                                          out_tvalid,
  input  wire logic                                     out_tready,
  output logic [tbd_pkg::OUT_TDATA_W-1:0]               out_tdata
);
  import tbd_pkg::*;

  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [OUT_TDATA_W-1:0] packed_nxt;

  // field order: all modes, then all held times, then all idle times
  always_comb begin
    packed_nxt = '0;
    for (int b = 0; b < NUM_BTN; b++) begin
      packed_nxt[b*MODE_W +: MODE_W] = lane_res[b].mode;
      packed_nxt[NUM_BTN*MODE_W + b*TIME_W +: TIME_W] = lane_res[b].held;
      packed_nxt[NUM_BTN*(MODE_W+TIME_W) + b*TIME_W +: TIME_W] = lane_res[b].idle;
    end
  end

  // a new beat may enter when none is held or the held one leaves in the same cycle
  assign in_ready = !out_valid_r || out_tready;

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) out_data_r <= packed_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire
